// ===== hw/rtl/bca_pkg.sv =====
// ----------------------------------------------------------------------------
// bca_pkg: shared types and constants for the block chain allocator
// Request and status codes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bca_pkg;

    localparam int FIELD_W = 11;

    localparam logic [2:0] REQ_ALLOC      = 3'd0;
    localparam logic [2:0] REQ_FREE       = 3'd1;
    localparam logic [2:0] REQ_FREE_CHAIN = 3'd2;
    localparam logic [2:0] REQ_SET_LINK   = 3'd3;
    localparam logic [2:0] REQ_READ_LINK  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_LIMIT = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALC_RD,
        S_ALC_CHK,
        S_FREE_CHK,
        S_FREE_UPD,
        S_CH_CHK,
        S_CH_UPD,
        S_LNK_SET,
        S_LNK_RD,
        S_LNK_CAP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    accept;       // latch request, init scan and result
        logic    clr_wr;       // clear one map word, advance clear pointer
        logic    map_rd_scan;  // read map word at scan pointer
        logic    scan_adv;     // move scan to next word
        logic    alloc_commit; // mark found block used, link to end, move hint
        logic    map_rd_cur;   // read map word holding current block
        logic    link_rd_cur;  // read link of current block
        logic    free_upd;     // clear current block bit, lower hint, count
        logic    chain_next;   // current block <= link just read
        logic    link_wr_tgt;  // write link target to current block
        logic    link_cap;     // result block <= link just read
        logic    set_status;
        t_status status_val;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic cur_in_range;
        logic cur_is_end;
        logic freed_full;
        logic clr_last;
        logic found;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/bca_dp.sv =====
// ----------------------------------------------------------------------------
// bca_dp: allocator datapath
// Used-bit map memory, link table memory, search hint, scan and chain
// registers, result staging and the output register.
// ----------------------------------------------------------------------------
module bca_dp import bca_pkg::*; #(
    parameter int NUM_BLOCKS    = 1024,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [FIELD_W-1:0] i_block_index,
    input  logic [FIELD_W-1:0] i_link_target,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic [FIELD_W-1:0] o_block_out,
    output logic [FIELD_W-1:0] o_freed_count
);

    localparam int IDX_W     = $clog2(NUM_BLOCKS);
    localparam int CNT_BITS  = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W     = (CNT_BITS > FIELD_W) ? CNT_BITS : FIELD_W;
    localparam int PW        = CMP_W + 1;
    // map words are rounded up to a power of two so index splits are shifts
    localparam int OFF_W     = $clog2(MAP_WORD_BITS);
    localparam int WORD_BITS = 1 << OFF_W;
    localparam int WORDS     = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SC_W      = $clog2(WORDS + 1);
    localparam logic [FIELD_W-1:0] END_MARK  = FIELD_W'(NUM_BLOCKS);
    localparam logic [CMP_W-1:0]   NUM_W     = CMP_W'(NUM_BLOCKS);
    localparam logic [PW-1:0]      NUM_P     = PW'(NUM_BLOCKS);
    localparam logic [WA_W-1:0]    LAST_WORD = WA_W'(WORDS - 1);

    logic [WORD_BITS-1:0] mem_map  [WORDS];
    logic [FIELD_W-1:0]   mem_link [NUM_BLOCKS];

    logic [FIELD_W-1:0]   r_cur;
    logic [FIELD_W-1:0]   r_tgt;
    logic [IDX_W-1:0]     r_hint;
    logic [WA_W-1:0]      r_ptr;
    logic [SC_W-1:0]      r_scan_cnt;
    logic                 r_first;
    logic [WA_W-1:0]      r_clr_ptr;
    logic [CNT_BITS-1:0]  r_freed;
    logic [WORD_BITS-1:0] r_map_rd;
    logic [FIELD_W-1:0]   r_link_rd;
    t_status              r_res_status;
    logic [FIELD_W-1:0]   r_res_block;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [FIELD_W-1:0]   r_out_block;
    logic [FIELD_W-1:0]   r_out_freed;

    logic [CMP_W-1:0]     cur_wide;
    logic [CMP_W-1:0]     hint_wide;
    logic [CMP_W-1:0]     cur_shift;
    logic [CMP_W-1:0]     hint_shift;
    logic [WA_W-1:0]      cur_word;
    logic [OFF_W-1:0]     cur_bit;
    logic [WA_W-1:0]      hint_word;
    logic [OFF_W-1:0]     hint_bit;
    logic [PW-1:0]        base;
    logic [WORD_BITS-1:0] avail;
    logic                 found;
    logic [OFF_W-1:0]     fbit;
    logic [PW-1:0]        fidx;
    logic [PW-1:0]        fidx_inc;

    logic                 map_we;
    logic [WA_W-1:0]      map_wa;
    logic [WORD_BITS-1:0] map_wd;
    logic                 map_re;
    logic [WA_W-1:0]      map_ra;
    logic                 link_we;
    logic [IDX_W-1:0]     link_wa;
    logic [FIELD_W-1:0]   link_wd;

    assign cur_wide   = CMP_W'(r_cur);
    assign hint_wide  = CMP_W'(r_hint);
    assign cur_shift  = cur_wide >> OFF_W;
    assign hint_shift = hint_wide >> OFF_W;
    assign cur_word   = cur_shift[WA_W-1:0];
    assign cur_bit    = cur_wide[OFF_W-1:0];
    assign hint_word  = hint_shift[WA_W-1:0];
    assign hint_bit   = hint_wide[OFF_W-1:0];
    assign base       = PW'(r_ptr) << OFF_W;

    // free bits of the scanned word; bits below the hint are skipped on the
    // first pass, bits past the pool end never count
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            avail[b] = !r_map_rd[b] && ((base + PW'(b)) < NUM_P)
                       && !(r_first && (OFF_W'(b) < hint_bit));
        end
    end

    always_comb begin
        found = 1'b0;
        fbit  = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (avail[b]) begin
                found = 1'b1;
                fbit  = OFF_W'(b);
            end
        end
    end

    assign fidx     = base | PW'(fbit);
    assign fidx_inc = fidx + PW'(1);

    always_comb begin
        map_we = 1'b0;
        map_wa = r_ptr;
        map_wd = r_map_rd;
        if (i_cmd.clr_wr) begin
            map_we = 1'b1;
            map_wa = r_clr_ptr;
            map_wd = '0;
        end else if (i_cmd.alloc_commit) begin
            map_we = 1'b1;
            map_wa = r_ptr;
            map_wd = r_map_rd | (WORD_BITS'(1) << fbit);
        end else if (i_cmd.free_upd) begin
            map_we = 1'b1;
            map_wa = cur_word;
            map_wd = r_map_rd & ~(WORD_BITS'(1) << cur_bit);
        end
    end

    assign map_re = i_cmd.map_rd_scan | i_cmd.map_rd_cur;
    assign map_ra = i_cmd.map_rd_scan ? r_ptr : cur_word;

    always_comb begin
        link_we = 1'b0;
        link_wa = cur_wide[IDX_W-1:0];
        link_wd = r_tgt;
        if (i_cmd.alloc_commit) begin
            link_we = 1'b1;
            link_wa = fidx[IDX_W-1:0];
            link_wd = END_MARK;
        end else if (i_cmd.link_wr_tgt) begin
            link_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[map_wa] <= map_wd;
        end
        if (map_re) begin
            r_map_rd <= mem_map[map_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            mem_link[link_wa] <= link_wd;
        end
        if (i_cmd.link_rd_cur) begin
            r_link_rd <= mem_link[cur_wide[IDX_W-1:0]];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hint      <= '0;
            r_clr_ptr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_ptr <= r_clr_ptr + WA_W'(1);
            end
            if (i_cmd.alloc_commit) begin
                r_hint <= (fidx_inc == NUM_P) ? '0 : fidx_inc[IDX_W-1:0];
            end else if (i_cmd.free_upd && (cur_wide < hint_wide)) begin
                r_hint <= cur_wide[IDX_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur        <= i_block_index;
            r_tgt        <= i_link_target;
            r_ptr        <= hint_word;
            r_first      <= 1'b1;
            r_scan_cnt   <= '0;
            r_freed      <= '0;
            r_res_status <= ST_OK;
            r_res_block  <= END_MARK;
        end else begin
            if (i_cmd.scan_adv) begin
                r_ptr      <= (r_ptr == LAST_WORD) ? '0 : r_ptr + WA_W'(1);
                r_first    <= 1'b0;
                r_scan_cnt <= r_scan_cnt + SC_W'(1);
            end
            if (i_cmd.alloc_commit) begin
                r_res_block <= fidx[FIELD_W-1:0];
            end
            if (i_cmd.link_cap) begin
                r_res_block <= r_link_rd;
            end
            if (i_cmd.free_upd) begin
                r_freed <= r_freed + CNT_BITS'(1);
            end
            if (i_cmd.chain_next) begin
                r_cur <= r_link_rd;
            end
            if (i_cmd.set_status) begin
                r_res_status <= i_cmd.status_val;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_block  <= r_res_block;
            r_out_freed  <= FIELD_W'(r_freed);
        end
    end

    assign o_sts.cur_in_range = cur_wide < NUM_W;
    assign o_sts.cur_is_end   = cur_wide == NUM_W;
    assign o_sts.freed_full   = CMP_W'(r_freed) == NUM_W;
    assign o_sts.clr_last     = r_clr_ptr == LAST_WORD;
    assign o_sts.found        = found;
    assign o_sts.scan_last    = r_scan_cnt == SC_W'(WORDS);
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_block_out   = r_out_block;
    assign o_freed_count = r_out_freed;

endmodule

// ===== hw/rtl/bca_ctrl.sv =====
// ----------------------------------------------------------------------------
// bca_ctrl: allocator controller
// Sequences the map clear after reset and each request type, driving
// datapath commands from datapath status.
// ----------------------------------------------------------------------------
module bca_ctrl import bca_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_req_type,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_req_type)
                        REQ_ALLOC:      n_state = S_ALC_RD;
                        REQ_FREE:       n_state = S_FREE_CHK;
                        REQ_FREE_CHAIN: n_state = S_CH_CHK;
                        REQ_SET_LINK:   n_state = S_LNK_SET;
                        REQ_READ_LINK:  n_state = S_LNK_RD;
                        default:        n_state = S_DONE;
                    endcase
                end
            end
            S_ALC_RD: begin
                o_cmd.map_rd_scan = 1'b1;
                n_state = S_ALC_CHK;
            end
            S_ALC_CHK: begin
                if (i_sts.found) begin
                    o_cmd.alloc_commit = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.scan_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state = S_ALC_RD;
                end
            end
            S_FREE_CHK: begin
                if (i_sts.cur_in_range) begin
                    o_cmd.map_rd_cur = 1'b1;
                    n_state = S_FREE_UPD;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = ST_RANGE;
                    n_state = S_DONE;
                end
            end
            S_FREE_UPD: begin
                o_cmd.free_upd = 1'b1;
                n_state = S_DONE;
            end
            S_CH_CHK: begin
                if (i_sts.cur_is_end) begin
                    n_state = S_DONE;
                end else if (!i_sts.cur_in_range) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = ST_RANGE;
                    n_state = S_DONE;
                end else if (i_sts.freed_full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = ST_LIMIT;
                    n_state = S_DONE;
                end else begin
                    o_cmd.map_rd_cur  = 1'b1;
                    o_cmd.link_rd_cur = 1'b1;
                    n_state = S_CH_UPD;
                end
            end
            S_CH_UPD: begin
                o_cmd.free_upd   = 1'b1;
                o_cmd.chain_next = 1'b1;
                n_state = S_CH_CHK;
            end
            S_LNK_SET: begin
                if (i_sts.cur_in_range) begin
                    o_cmd.link_wr_tgt = 1'b1;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = ST_RANGE;
                end
                n_state = S_DONE;
            end
            S_LNK_RD: begin
                if (i_sts.cur_in_range) begin
                    o_cmd.link_rd_cur = 1'b1;
                    n_state = S_LNK_CAP;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = ST_RANGE;
                    n_state = S_DONE;
                end
            end
            S_LNK_CAP: begin
                o_cmd.link_cap = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to be free
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/block_chain_allocator.sv =====
// Steps: allocate reads and checks map words from the hint (up to words + 1 words);
//   free reads then writes the map word, free chain does so and reads the link per block.
// Throughput: one item at a time; the map and link memories each have one write and
//   one read address, and map updates are a registered read then a write.
// Reset: synchronous; a clear pass then writes the used map one word per cycle
//   with no item accepted.
// ----------------------------------------------------------------------------
// block_chain_allocator: next-fit block allocator with chained links
// Used-bit map search from a hint, single and chain frees, link access.
// ----------------------------------------------------------------------------
module block_chain_allocator import bca_pkg::*; #(
    parameter int NUM_BLOCKS    = 1024,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_req_type,
    input  logic [FIELD_W-1:0] i_block_index,
    input  logic [FIELD_W-1:0] i_link_target,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [FIELD_W-1:0] o_block_out,
    output logic [FIELD_W-1:0] o_freed_count
);

    t_cmd cmd;
    t_sts sts;

    bca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    bca_dp #(
        .NUM_BLOCKS    (NUM_BLOCKS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_block_index (i_block_index),
        .i_link_target (i_link_target),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_block_out   (o_block_out),
        .o_freed_count (o_freed_count)
    );

`ifndef SYNTHESIS
    localparam logic [FIELD_W-1:0] END_CHK = FIELD_W'(NUM_BLOCKS);

    // nothing is taken while the map clear runs
    a_no_accept_after_reset: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) !$past(i_rst_n) |-> !o_in_ready)
        else $error("item accepted during map clear");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |->
        (o_block_out == END_CHK) && (o_freed_count == '0))
        else $error("pool full result carries a block or a count");

    a_freed_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_freed_count != '0)) |-> (o_block_out == END_CHK))
        else $error("free result carries a block");

    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_LIMIT)) |->
        (o_freed_count == FIELD_W'(NUM_BLOCKS)))
        else $error("walk limit without a full count");
`endif

endmodule

// ===== tb/block_chain_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_chain_allocator_tb: self-checking testbench for the block allocator
// Sends allocate, free, chain free, link set/read and unused requests over the
// valid/ready ports. Each reply is predicted from a local copy of the used map,
// search hint and link table, and replies are checked in order of acceptance.
// ----------------------------------------------------------------------------
module block_chain_allocator_tb import bca_pkg::*;;

    localparam int NB           = 1024;
    localparam int FIELD_TOP    = (1 << FIELD_W) - 1;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int TAIL_CYCLES  = 80;
    localparam int LONG_CHAIN   = 64;
    localparam int REFILL_FREES = 64;
    localparam logic [FIELD_W-1:0] LINK_END  = FIELD_W'(NB);
    localparam logic [FIELD_W-1:0] FIELD_ALL = '1;

    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] block;
        logic [FIELD_W-1:0] freed;
    } t_reply;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_req_type    = '0;
    logic [FIELD_W-1:0] i_block_index = '0;
    logic [FIELD_W-1:0] i_link_target = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [1:0]         o_status;
    logic [FIELD_W-1:0] o_block_out;
    logic [FIELD_W-1:0] o_freed_count;

    // predicted pool state
    bit                 blk_used   [NB];
    logic [FIELD_W-1:0] blk_link   [NB];
    bit                 link_valid [NB];
    int                 next_hint  = 0;

    t_reply reply_q [$];
    int     mism_cnt   = 0;
    int     ops_sent   = 0;
    int     idle_mode  = 0;   // 0 none, 1 light, 2 heavy
    int     limit_left = 3;   // chain walks allowed to hit the step limit
    int     cyc        = 0;

    block_chain_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_block_index (i_block_index),
        .i_link_target (i_link_target),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_block_out   (o_block_out),
        .o_freed_count (o_freed_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Pool prediction
    // ------------------------------------------------------------------------
    function automatic void release_block(int b);
        blk_used[b] = 1'b0;
        if (b < next_hint) next_hint = b;
    endfunction

    function automatic t_reply pool_update(logic [2:0] req, logic [FIELD_W-1:0] idx,
                                           logic [FIELD_W-1:0] tgt);
        t_reply r;
        int     n, b, cur, nxt, freed_n;
        bit     found, done;
        r.status = ST_OK;
        r.block  = LINK_END;
        r.freed  = '0;
        freed_n  = 0;
        case (req)
            REQ_ALLOC: begin
                r.status = ST_FULL;
                found    = 1'b0;
                for (n = 0; n < NB && !found; n++) begin
                    b = (next_hint + n) % NB;
                    if (!blk_used[b]) begin
                        found         = 1'b1;
                        blk_used[b]   = 1'b1;
                        blk_link[b]   = LINK_END;
                        link_valid[b] = 1'b1;
                        next_hint     = (b + 1) % NB;
                        r.status      = ST_OK;
                        r.block       = FIELD_W'(b);
                    end
                end
            end
            REQ_FREE: begin
                if (idx >= NB) r.status = ST_RANGE;
                else begin
                    release_block(int'(idx));
                    freed_n = 1;
                end
            end
            REQ_FREE_CHAIN: begin
                cur  = int'(idx);
                done = 1'b0;
                while (!done) begin
                    if (cur == NB) done = 1'b1;
                    else if (cur > NB) begin
                        r.status = ST_RANGE;
                        done     = 1'b1;
                    end else if (freed_n >= NB) begin
                        r.status = ST_LIMIT;
                        done     = 1'b1;
                    end else begin
                        nxt = int'(blk_link[cur]);
                        release_block(cur);
                        freed_n++;
                        cur = nxt;
                    end
                end
            end
            REQ_SET_LINK: begin
                if (idx >= NB) r.status = ST_RANGE;
                else begin
                    blk_link[idx]   = tgt;
                    link_valid[idx] = 1'b1;
                end
            end
            REQ_READ_LINK: begin
                if (idx >= NB) r.status = ST_RANGE;
                else r.block = blk_link[idx];
            end
            default: ;
        endcase
        r.freed = FIELD_W'(freed_n);
        return r;
    endfunction

    // Walks the predicted links from head without changing anything. Fails if
    // the walk would read a link entry that was never written.
    function automatic bit chain_safe(logic [FIELD_W-1:0] head, output int steps);
        int cur;
        bit ok;
        cur   = int'(head);
        steps = 0;
        ok    = 1'b1;
        while (ok && cur < NB && steps < NB) begin
            if (!link_valid[cur]) ok = 1'b0;
            else begin
                cur = int'(blk_link[cur]);
                steps++;
            end
        end
        return ok;
    endfunction

    function automatic logic [FIELD_W-1:0] rand11();
        return FIELD_W'($urandom_range(0, FIELD_TOP));
    endfunction

    // in-range index with a written link, else an out-of-range one
    function automatic logic [FIELD_W-1:0] written_block();
        int t, c;
        for (t = 0; t < 16; t++) begin
            c = $urandom_range(0, NB - 1);
            if (link_valid[c]) return FIELD_W'(c);
        end
        return FIELD_W'($urandom_range(NB, FIELD_TOP));
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_req(input logic [2:0] req, input logic [FIELD_W-1:0] idx,
                            input logic [FIELD_W-1:0] tgt, output t_reply rep);
        int gap;
        gap = 0;
        if (idle_mode == 1 && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 15);
        if (idle_mode == 2 && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_block_index <= idx;
        i_link_target <= tgt;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        rep = pool_update(req, idx, tgt);
        reply_q.push_back(rep);
        if (req <= REQ_READ_LINK) ops_sent++;
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (reply_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Reply side
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_mode != 0 && $urandom_range(0, idle_mode == 2 ? 3 : 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (reply_q.size() == 0) begin
                mism_cnt++;
                if (mism_cnt <= 10)
                    $display("reply with none pending: status %0d block %0d freed %0d",
                             o_status, o_block_out, o_freed_count);
            end else begin
                want = reply_q.pop_front();
                if (o_status !== want.status || o_block_out !== want.block ||
                    o_freed_count !== want.freed) begin
                    mism_cnt++;
                    if (mism_cnt <= 10)
                        $display({"reply mismatch: expected status %0d block %0d freed %0d,",
                                  " got status %0d block %0d freed %0d"},
                                 want.status, want.block, want.freed,
                                 o_status, o_block_out, o_freed_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed;
        t_reply rep;
        int     k;
        idle_mode = 1;
        repeat (3) send_req(REQ_ALLOC, rand11(), rand11(), rep);
        send_req(REQ_READ_LINK, 11'd0, rand11(), rep);
        send_req(REQ_SET_LINK, 11'd0, 11'd1, rep);
        send_req(REQ_SET_LINK, 11'd1, 11'd2, rep);
        send_req(REQ_READ_LINK, 11'd1, rand11(), rep);
        send_req(REQ_FREE_CHAIN, 11'd0, rand11(), rep);
        send_req(REQ_FREE_CHAIN, LINK_END, rand11(), rep);      // empty chain
        send_req(REQ_FREE_CHAIN, FIELD_ALL, rand11(), rep);     // bad head
        send_req(REQ_FREE, LINK_END, rand11(), rep);
        send_req(REQ_FREE, FIELD_ALL, rand11(), rep);
        send_req(REQ_FREE, 11'd5, rand11(), rep);               // already free
        // link past the pool ends the walk with a range error
        send_req(REQ_SET_LINK, FIELD_W'(NB - 1), FIELD_ALL, rep);
        send_req(REQ_READ_LINK, FIELD_W'(NB - 1), rand11(), rep);
        send_req(REQ_FREE_CHAIN, FIELD_W'(NB - 1), rand11(), rep);
        send_req(REQ_SET_LINK, FIELD_ALL, 11'd0, rep);
        send_req(REQ_READ_LINK, LINK_END, rand11(), rep);
        for (k = 1; k <= 3; k++)
            send_req(REQ_READ_LINK + 3'(k), k == 3 ? FIELD_ALL : rand11(),
                     k == 3 ? FIELD_ALL : rand11(), rep);
        // self loop: walk stops at the step limit
        send_req(REQ_SET_LINK, FIELD_W'(NB - 1), FIELD_W'(NB - 1), rep);
        send_req(REQ_FREE_CHAIN, FIELD_W'(NB - 1), rand11(), rep);
    endtask

    task automatic test_random_ops(input int n, input bit with_idle);
        t_reply             rep;
        logic [FIELD_W-1:0] chain_blk [8];
        logic [FIELD_W-1:0] idx, tgt;
        logic [2:0]         req;
        int                 target, k, j, cnt, pick, steps;
        target = ops_sent + n;
        while (ops_sent < target) begin
            if (with_idle && $urandom_range(0, 29) == 0) idle_mode = $urandom_range(0, 2);
            if ($urandom_range(0, 9) < 4) begin
                // allocate a few blocks, link them, then mostly free the chain
                k   = $urandom_range(1, 6);
                cnt = 0;
                for (j = 0; j < k; j++) begin
                    send_req(REQ_ALLOC, rand11(), rand11(), rep);
                    if (rep.status == ST_OK) begin
                        chain_blk[cnt] = rep.block;
                        cnt++;
                    end
                end
                for (j = 0; j < cnt; j++) begin
                    if (j < cnt - 1) tgt = chain_blk[j + 1];
                    else if ($urandom_range(0, 5) == 0)
                        tgt = FIELD_W'($urandom_range(NB + 1, FIELD_TOP));
                    else tgt = LINK_END;
                    send_req(REQ_SET_LINK, chain_blk[j], tgt, rep);
                end
                if (cnt > 0 && $urandom_range(0, 1) == 1)
                    send_req(REQ_READ_LINK, chain_blk[$urandom_range(0, cnt - 1)],
                             rand11(), rep);
                if (cnt > 0 && $urandom_range(0, 3) != 0) begin
                    idx = ($urandom_range(0, 4) == 0) ? chain_blk[$urandom_range(0, cnt - 1)]
                                                      : chain_blk[0];
                    send_req(REQ_FREE_CHAIN, idx, rand11(), rep);
                end
            end else begin
                pick = $urandom_range(0, 9);
                idx  = rand11();
                tgt  = rand11();
                if (pick < 2) req = REQ_ALLOC;
                else if (pick < 4) begin
                    req = REQ_FREE;
                    if ($urandom_range(0, 4) != 0) idx = FIELD_W'(idx % NB);
                end else if (pick < 6) begin
                    req = REQ_SET_LINK;
                    if ($urandom_range(0, 4) != 0) idx = FIELD_W'(idx % NB);
                    case ($urandom_range(0, 2))
                        0:       tgt = LINK_END;
                        1:       tgt = written_block();
                        default: ;
                    endcase
                end else if (pick < 8) begin
                    req = REQ_READ_LINK;
                    if ($urandom_range(0, 4) != 0) idx = written_block();
                    else idx = FIELD_W'($urandom_range(NB, FIELD_TOP));
                end else if (pick < 9) begin
                    req = REQ_FREE_CHAIN;
                    case ($urandom_range(0, 4))
                        0:       idx = LINK_END;
                        1:       ;
                        default: idx = written_block();
                    endcase
                    // keep walks short and never through unwritten links, but let limit_left walks hit the step limit
                    if (!chain_safe(idx, steps) || (steps > LONG_CHAIN && steps < NB))
                        idx = LINK_END;
                    else if (steps == NB) begin
                        if (limit_left > 0) limit_left--;
                        else idx = LINK_END;
                    end
                end else req = REQ_READ_LINK + 3'($urandom_range(1, 3));
                send_req(req, idx, tgt, rep);
            end
        end
    endtask

    task automatic test_pool_full;
        t_reply rep;
        int     order [NB];
        int     j, k, tmp;
        idle_mode = 1;
        do send_req(REQ_ALLOC, rand11(), rand11(), rep); while (rep.status == ST_OK);
        send_req(REQ_ALLOC, rand11(), rand11(), rep);
        // punch a few holes and refill them through the hint wrap
        for (j = 0; j < 6; j++)
            send_req(REQ_FREE, FIELD_W'($urandom_range(0, NB - 1)), rand11(), rep);
        for (j = 0; j < 7; j++) send_req(REQ_ALLOC, rand11(), rand11(), rep);
        for (j = 0; j < NB; j++) order[j] = j;
        for (j = NB - 1; j > 0; j--) begin
            k        = $urandom_range(0, j);
            tmp      = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        // leave room for the last random part
        for (j = 0; j < REFILL_FREES; j++)
            send_req(REQ_FREE, FIELD_W'(order[j]), rand11(), rep);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        wait_drained();
        idle_mode = 2;
        test_random_ops(120, 1'b1);
        wait_drained();
        test_pool_full();
        wait_drained();
        idle_mode = 0;
        test_random_ops(80, 1'b0);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mism_cnt == 0 && reply_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bca_pkg.sv
hw/rtl/bca_dp.sv
hw/rtl/bca_ctrl.sv
hw/rtl/block_chain_allocator.sv
tb/block_chain_allocator_tb.sv
